@@ design/rgbds_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbds_pkg
// Shared payload types and fixed constants of the RGB block-average downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbds_pkg;

  localparam int unsigned CFG_W      = 13;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [IDX_W-1:0] REG_RES_LEVEL    = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [1:0] RES_DIV16 = 2'd1;
  localparam logic [1:0] RES_DIV64 = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
    logic [5:0]  block_col;
    logic [11:0] block_row;
    logic        last_block;
  } res_t;

  typedef struct packed {
    logic [5:0]  block_col;
    logic [11:0] block_row;
    logic        last_block;
  } tag_t;

endpackage

`default_nettype wire

@@ design/rgbds_ram.sv @@
// ----------------------------------------------------------------------------
// rgbds_ram
// Simple dual-port RAM: one write port, one read port, registered read data
// (read-before-write on an address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module rgbds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/rgbds_div.sv @@
// ----------------------------------------------------------------------------
// rgbds_div
// Three-channel restoring divider, one quotient bit per cycle, with an output
// register that holds the finished word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbds_div #(
  parameter int unsigned SUM_W  = 24,
  parameter int unsigned AREA_W = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [SUM_W-1:0]     sum_red,
  input  wire logic [SUM_W-1:0]     sum_green,
  input  wire logic [SUM_W-1:0]     sum_blue,
  input  wire logic [AREA_W-1:0]    area,
  input  wire rgbds_pkg::tag_t      tag,
  output logic                      busy,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rgbds_pkg::res_t           out_data
);

  import rgbds_pkg::*;

  logic [SUM_W-1:0] rem_r   [3];
  logic [SUM_W-1:0] rem_nxt [3];
  logic [7:0]       q_r     [3];
  logic [7:0]       q_nxt   [3];
  logic [2:0]       k_r;
  logic             run_r;
  logic             out_valid_r;
  tag_t             tag_r;
  res_t             out_r;
  logic [SUM_W-1:0] dsh;

  // Quotient never exceeds 255, so eight steps finish the division.
  always_comb begin
    dsh = SUM_W'(area) << k_r;
    for (int c = 0; c < 3; c++) begin
      if (rem_r[c] >= dsh) begin
        rem_nxt[c] = rem_r[c] - dsh;
        q_nxt[c]   = {q_r[c][6:0], 1'b1};
      end else begin
        rem_nxt[c] = rem_r[c];
        q_nxt[c]   = {q_r[c][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= 3'd0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (start) begin
        run_r <= 1'b1;
        k_r   <= 3'd7;
      end else if (run_r) begin
        k_r <= k_r - 3'd1;
        if (k_r == 3'd0) begin
          run_r       <= 1'b0;
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r[0] <= sum_red;
      rem_r[1] <= sum_green;
      rem_r[2] <= sum_blue;
      for (int c = 0; c < 3; c++) q_r[c] <= 8'd0;
      tag_r <= tag;
    end else if (run_r) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= rem_nxt[c];
        q_r[c]   <= q_nxt[c];
      end
      if (k_r == 3'd0) begin
        out_r.avg_red    <= q_nxt[0];
        out_r.avg_green  <= q_nxt[1];
        out_r.avg_blue   <= q_nxt[2];
        out_r.block_col  <= tag_r.block_col;
        out_r.block_row  <= tag_r.block_row;
        out_r.last_block <= tag_r.last_block;
      end
    end
  end

  assign busy      = run_r | out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ design/rgb_block_average_downscaler.sv @@
// ----------------------------------------------------------------------------
// rgb_block_average_downscaler
// Block-average downscaler for a raster RGB stream, column sums kept in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel word per handshake, raster order, valid/ready.
//   out_* : one word per completed block (averages, block column/row, last
//           flag), valid/ready, held in an output register until taken.
//   cfg_* : write-only registers; every write to a defined register (index 0 to 2) restarts the image.
// Throughput: one pixel per cycle. A pixel that completes a block stalls
//   the input while the divider produces eight quotient bits, and the next
//   pixel waits until the previous block word is taken.
// Output: the block's bottom-right pixel is registered in the accumulate stage,
//   its sums start the divider, and out_valid follows the last quotient bit.
// Reset and every write to a defined config register run a setup pass: the
//   column-sum RAM is cleared one entry a cycle and the block count and crop
//   margins are divided out bit-serially. in_ready stays low during that pass.
// Receiver stall: the output word holds; once the divider is full, in_ready
//   drops until the word is taken.
// Column sums: read at acceptance, added in the next cycle and written back;
//   a one-deep forward covers a pixel that reads the entry just written.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_block_average_downscaler #(
  parameter int unsigned MAX_WIDTH      = 4096,
  parameter int unsigned MAX_BLOCK_COLS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire rgbds_pkg::pix_t             in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rgbds_pkg::res_t                  out_data,
  input  wire logic                        cfg_we,
  input  wire logic [rgbds_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [rgbds_pkg::CFG_W-1:0] cfg_data
);

  import rgbds_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_BLOCK_COLS);
  localparam int unsigned PW      = $clog2(MAX_WIDTH);
  localparam int unsigned WW      = PW + 1;
  localparam int unsigned HW      = CFG_W;
  localparam int unsigned RW      = HW - 1;
  localparam int unsigned SW      = $clog2(MAX_WIDTH / 16) + 1;
  localparam int unsigned AREA_W  = 2 * SW;
  localparam int unsigned SUM_W   = 8 + AREA_W;
  localparam int unsigned DW      = (WW > HW) ? WW : HW;
  localparam int unsigned SETUP_N = (MAX_BLOCK_COLS > DW + 1) ? MAX_BLOCK_COLS : DW + 1;
  localparam int unsigned CW      = $clog2(SETUP_N);

  // Config registers
  logic [1:0]       res_level_r;
  logic [CFG_W-1:0] image_width_r;
  logic [CFG_W-1:0] image_height_r;

  // Setup pass
  logic          setup_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] num_w_r, num_h_r, num_w_nxt, num_h_nxt;
  logic [SW:0]   rem_w_r, rem_h_r, rem_w_nxt, rem_h_nxt, rsh_w, rsh_h;
  logic [AREA_W-1:0] area_r;

  // Raster position and block counters
  logic [PW-1:0] pc_r, pc_nxt;
  logic [RW-1:0] pr_r, pr_nxt;
  logic [SW-1:0] xs_r, xs_nxt, ys_r, ys_nxt;
  logic [WW-1:0] bc_r, bc_nxt;
  logic [HW-1:0] br_r, br_nxt;

  // Accumulate stage
  logic              s1_v_r, s1_emit_r;
  logic [AW-1:0]     s1_addr_r;
  pix_t              s1_pix_r;
  tag_t              s1_tag_r;
  logic              fwd_v_r;
  logic [AW-1:0]     fwd_addr_r;
  logic [3*SUM_W-1:0] fwd_data_r;

  // Derived geometry
  logic [WW-1:0] eff_w, sh_w, ncols, kept, xend, left, right;
  logic [HW-1:0] eff_h, nrows, yend, top, bottom;
  logic [SW-1:0] blk, blk_m1, rw, rh;

  logic          acc, in_col, in_row, keep, at_xe, at_ye, row_end;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [3*SUM_W-1:0] ram_wdata, ram_rdata, base, new_sum;
  logic          dv_busy;
  tag_t          tag_now;

  always_comb begin
    if (image_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_r);
    end
    if (image_height_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(image_height_r) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = image_height_r;
    end
    priority if (res_level_r == RES_DIV16) begin
      sh_w = eff_w >> 4;
    end else if (res_level_r == RES_DIV64) begin
      sh_w = eff_w >> 6;
    end else begin
      sh_w = eff_w >> 5;
    end
    blk    = (sh_w == '0) ? SW'(1) : sh_w[SW-1:0];
    blk_m1 = blk - SW'(1);
  end

  // Bit-serial division of width and height by the block size.
  always_comb begin
    rsh_w = {rem_w_r[SW-1:0], num_w_r[DW-1]};
    rsh_h = {rem_h_r[SW-1:0], num_h_r[DW-1]};
    if (rsh_w >= {1'b0, blk}) begin
      rem_w_nxt = rsh_w - {1'b0, blk};
      num_w_nxt = {num_w_r[DW-2:0], 1'b1};
    end else begin
      rem_w_nxt = rsh_w;
      num_w_nxt = {num_w_r[DW-2:0], 1'b0};
    end
    if (rsh_h >= {1'b0, blk}) begin
      rem_h_nxt = rsh_h - {1'b0, blk};
      num_h_nxt = {num_h_r[DW-2:0], 1'b1};
    end else begin
      rem_h_nxt = rsh_h;
      num_h_nxt = {num_h_r[DW-2:0], 1'b0};
    end
  end

  always_comb begin
    ncols  = num_w_r[WW-1:0];
    nrows  = num_h_r[HW-1:0];
    rw     = rem_w_r[SW-1:0];
    rh     = rem_h_r[SW-1:0];
    left   = WW'(rw >> 1);
    right  = WW'(rw) - left;
    xend   = eff_w - right;
    top    = HW'(rh >> 1);
    bottom = HW'(rh) - top;
    yend   = eff_h - bottom;
    kept   = (ncols < WW'(MAX_BLOCK_COLS)) ? ncols : WW'(MAX_BLOCK_COLS);
  end

  // Position tracking
  always_comb begin
    in_col  = (WW'(pc_r) >= left) && (WW'(pc_r) < xend);
    in_row  = (HW'(pr_r) >= top) && (HW'(pr_r) < yend);
    keep    = in_col && in_row && (bc_r < WW'(MAX_BLOCK_COLS));
    at_xe   = (xs_r == blk_m1);
    at_ye   = (ys_r == blk_m1);
    row_end = (WW'(pc_r) == eff_w - WW'(1));
    acc     = in_valid && in_ready;

    tag_now.block_col  = bc_r[5:0];
    tag_now.block_row  = br_r[11:0];
    tag_now.last_block = (br_r + HW'(1) == nrows) && (bc_r + WW'(1) == kept);

    pc_nxt = pc_r;
    pr_nxt = pr_r;
    xs_nxt = xs_r;
    ys_nxt = ys_r;
    bc_nxt = bc_r;
    br_nxt = br_r;
    if (in_col) begin
      xs_nxt = at_xe ? '0 : xs_r + SW'(1);
      bc_nxt = at_xe ? bc_r + WW'(1) : bc_r;
    end
    if (row_end) begin
      pc_nxt = '0;
      xs_nxt = '0;
      bc_nxt = '0;
      if (in_row) begin
        ys_nxt = at_ye ? '0 : ys_r + SW'(1);
        br_nxt = at_ye ? br_r + HW'(1) : br_r;
      end
      if (HW'(pr_r) == eff_h - HW'(1)) begin
        pr_nxt = '0;
        ys_nxt = '0;
        br_nxt = '0;
      end else begin
        pr_nxt = pr_r + RW'(1);
      end
    end else begin
      pc_nxt = pc_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_level_r    <= 2'd2;
      image_width_r  <= CFG_W'(640);
      image_height_r <= CFG_W'(480);
      setup_r        <= 1'b1;
      cnt_r          <= '0;
      pc_r <= '0; pr_r <= '0; xs_r <= '0; ys_r <= '0; bc_r <= '0; br_r <= '0;
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else if (cfg_we && (cfg_index == REG_RES_LEVEL || cfg_index == REG_IMAGE_WIDTH ||
                            cfg_index == REG_IMAGE_HEIGHT)) begin
      unique case (cfg_index)
        REG_RES_LEVEL:   res_level_r    <= cfg_data[1:0];
        REG_IMAGE_WIDTH: image_width_r  <= cfg_data;
        default:         image_height_r <= cfg_data;
      endcase
      // Restart the image: clear sums, position and derived geometry.
      setup_r <= 1'b1;
      cnt_r   <= '0;
      pc_r <= '0; pr_r <= '0; xs_r <= '0; ys_r <= '0; bc_r <= '0; br_r <= '0;
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (setup_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (32'(cnt_r) == SETUP_N - 1) begin
          setup_r <= 1'b0;
        end
      end
      fwd_v_r <= s1_v_r;
      s1_v_r  <= acc && keep;
      if (acc) begin
        pc_r <= pc_nxt; pr_r <= pr_nxt; xs_r <= xs_nxt;
        ys_r <= ys_nxt; bc_r <= bc_nxt; br_r <= br_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (setup_r) begin
      area_r <= AREA_W'(blk) * AREA_W'(blk);
      if (cnt_r == '0) begin
        num_w_r <= DW'(eff_w);
        num_h_r <= DW'(eff_h);
        rem_w_r <= '0;
        rem_h_r <= '0;
      end else if (32'(cnt_r) <= DW) begin
        num_w_r <= num_w_nxt;
        num_h_r <= num_h_nxt;
        rem_w_r <= rem_w_nxt;
        rem_h_r <= rem_h_nxt;
      end
    end
    if (acc) begin
      s1_addr_r <= bc_r[AW-1:0];
      s1_pix_r  <= in_data;
      s1_tag_r  <= tag_now;
      s1_emit_r <= at_xe && at_ye;
    end
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= ram_wdata;
  end

  // Read-modify-write of the column sums
  always_comb begin
    base = (fwd_v_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : ram_rdata;
    new_sum[3*SUM_W-1:2*SUM_W] = base[3*SUM_W-1:2*SUM_W] + SUM_W'(s1_pix_r.red);
    new_sum[2*SUM_W-1:SUM_W]   = base[2*SUM_W-1:SUM_W]   + SUM_W'(s1_pix_r.green);
    new_sum[SUM_W-1:0]         = base[SUM_W-1:0]         + SUM_W'(s1_pix_r.blue);
    ram_we    = setup_r ? (32'(cnt_r) < MAX_BLOCK_COLS) : s1_v_r;
    ram_waddr = setup_r ? cnt_r[AW-1:0] : s1_addr_r;
    ram_wdata = (setup_r || s1_emit_r) ? '0 : new_sum;
  end

  // Hold input in setup, with a block end staged, or while the divider or its output word is busy.
  assign in_ready = !setup_r && !dv_busy && !(s1_v_r && s1_emit_r);

  rgbds_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_BLOCK_COLS)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bc_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  rgbds_div #(
    .SUM_W  (SUM_W),
    .AREA_W (AREA_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (s1_v_r && s1_emit_r),
    .sum_red   (new_sum[3*SUM_W-1:2*SUM_W]),
    .sum_green (new_sum[2*SUM_W-1:SUM_W]),
    .sum_blue  (new_sum[SUM_W-1:0]),
    .area      (area_r),
    .tag       (s1_tag_r),
    .busy      (dv_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_input_in_setup : assert property (@(posedge clk) disable iff (!rst_n)
    setup_r |-> !in_ready) else $error("input accepted during setup pass");

  a_emit_starts_div : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_emit_r && !cfg_we) |=> dv_busy) else $error("block word lost");

  a_cfg_restarts : assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == REG_RES_LEVEL || cfg_index == REG_IMAGE_WIDTH ||
                cfg_index == REG_IMAGE_HEIGHT)) |=> (setup_r && !s1_v_r))
    else $error("config write did not restart");

  a_busy_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    dv_busy |-> !in_ready) else $error("input accepted while divider busy");

endmodule

`default_nettype wire
